/* rtl/gos_pkg.sv */
// Package for the glyph outline segmenter: widths, codes, pipeline words
// and the scale and midpoint arithmetic. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package gos_pkg;

  localparam int PEN_BITS  = 24;
  localparam int SCALE_W   = 24;
  localparam int FIELD_W   = 16;
  localparam int CW        = 48;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  typedef logic signed [PEN_BITS-1:0] pen_t;
  typedef logic signed [CW-1:0]       coord_t;
  typedef logic [SCALE_W-1:0]         scale_t;
  typedef logic [1:0]                 nres_t;

  typedef enum logic [1:0] {
    KIND_MARK = 2'd0,
    KIND_LINE = 2'd1,
    KIND_QUAD = 2'd2
  } kind_t;

  // what a point does to the outline, decided when it is accepted
  typedef enum logic [2:0] {
    OP_MARK,
    OP_LINE,
    OP_QUAD_ON,
    OP_OFF_FIRST,
    OP_OFF_MID
  } op_t;

  typedef struct packed {
    op_t  op;
    logic cend;
    pen_t prev_x;
    pen_t prev_y;
    pen_t cur_x;
    pen_t cur_y;
  } s1_t;

  typedef struct packed {
    op_t    op;
    logic   cend;
    coord_t prev_x;
    coord_t prev_y;
    coord_t cur_x;
    coord_t cur_y;
  } s2_t;

  typedef struct packed {
    kind_t  kind;
    coord_t p0_x;
    coord_t p0_y;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    logic   last;
  } res_t;

  function automatic coord_t scale_coord(pen_t p, scale_t s);
    logic signed [PEN_BITS+SCALE_W:0] prod;
    prod = p * $signed({1'b0, s});
    return coord_t'(prod);
  endfunction

  // floor((a + b) / 2)
  function automatic coord_t midpoint(coord_t a, coord_t b);
    logic signed [CW:0] sum;
    sum = {a[CW-1], a} + {b[CW-1], b};
    return sum[CW:1];
  endfunction

endpackage
`default_nettype wire

/* rtl/gos_ifs.sv */
// Valid/ready channel interfaces: outline points in, segment words out.
// Depends on gos_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface point_if import gos_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] delta_x;
  logic signed [FIELD_W-1:0] delta_y;
  logic                      on_curve;
  logic                      contour_end;
  logic                      glyph_start;
  logic signed [FIELD_W-1:0] offset_x;
  logic signed [FIELD_W-1:0] offset_y;

  modport source (output valid, delta_x, delta_y, on_curve, contour_end, glyph_start,
                  offset_x, offset_y, input ready);
  modport sink (input valid, delta_x, delta_y, on_curve, contour_end, glyph_start,
                offset_x, offset_y, output ready);
endinterface

interface segment_if import gos_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  coord_t     p0_x;
  coord_t     p0_y;
  coord_t     p1_x;
  coord_t     p1_y;
  coord_t     p2_x;
  coord_t     p2_y;
  logic       last;

  modport source (output valid, kind, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, last,
                  input ready);
  modport sink (input valid, kind, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, last,
                output ready);
endinterface
`default_nettype wire

/* rtl/gos_seg_buf.sv */
// Two-entry result buffer: takes the one or two words of a point at once
// and hands them out one per cycle while seg.ready is high. Depends on gos_pkg and gos_ifs.
`timescale 1ns / 1ps
`default_nettype none
module gos_seg_buf import gos_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  nres_t     nres,
  input  res_t      r0,
  input  res_t      r1,
  output logic      free,
  segment_if.source seg
);

  res_t        slot0;
  res_t        slot1;
  logic [1:0]  cnt;
  logic        fire;

  assign fire = seg.valid && seg.ready;
  assign free = (cnt == 2'd0) || (cnt == 2'd1 && fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load && nres != 2'd0) begin
      cnt <= nres;
    end else if (fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && nres != 2'd0) begin
      slot0 <= r0;
      slot1 <= r1;
    end else if (fire) begin
      slot0 <= slot1;
    end
  end

  assign seg.valid = (cnt != 2'd0);
  assign seg.kind  = slot0.kind;
  assign seg.p0_x  = slot0.p0_x;
  assign seg.p0_y  = slot0.p0_y;
  assign seg.p1_x  = slot0.p1_x;
  assign seg.p1_y  = slot0.p1_y;
  assign seg.p2_x  = slot0.p2_x;
  assign seg.p2_y  = slot0.p2_y;
  assign seg.last  = slot0.last;

endmodule
`default_nettype wire

/* rtl/glyph_outline_segmenter.sv */
// Glyph outline segmenter: pen accumulate, scale multiply, segment build.
// Path: accept register s1, scale register s2, then the result buffer and the output.
// Throughput: one point per cycle while the output is not stalled; a point whose two
// words close a contour holds back the next point. Output is one word per cycle while seg.ready is high.
// Reset (rst, synchronous): pen zero, scale 1.0, awaiting a contour start.
// Depends on gos_pkg, gos_ifs, gos_seg_buf.
`timescale 1ns / 1ps
`default_nettype none
module glyph_outline_segmenter import gos_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  point_if.sink        point,
  segment_if.source    seg
);

  scale_t scale;
  pen_t   pen_x;
  pen_t   pen_y;
  logic   awaiting_first;
  logic   in_curve;

  logic   s1_valid;
  s1_t    s1;
  logic   s2_valid;
  s2_t    s2;

  coord_t origin_x, origin_y;
  coord_t cs_x, cs_y;
  coord_t cc_x, cc_y;

  logic   in_fire;
  logic   s2_take;
  logic   s2_load;
  logic   buf_free;

  // accept stage
  logic   aw_eff, ic_eff;
  pen_t   base_x, base_y;
  pen_t   pen_x_next, pen_y_next;
  op_t    op_next;

  assign in_fire = point.valid && point.ready;
  assign point.ready = !s1_valid || s2_take;

  always_comb begin
    aw_eff = awaiting_first || point.glyph_start;
    ic_eff = in_curve && !point.glyph_start;
    base_x = point.glyph_start ? pen_t'(point.offset_x) : pen_x;
    base_y = point.glyph_start ? pen_t'(point.offset_y) : pen_y;
    pen_x_next = base_x + pen_t'(point.delta_x);
    pen_y_next = base_y + pen_t'(point.delta_y);
    if (aw_eff) begin
      op_next = OP_MARK;
    end else if (point.on_curve) begin
      op_next = ic_eff ? OP_QUAD_ON : OP_LINE;
    end else begin
      op_next = ic_eff ? OP_OFF_MID : OP_OFF_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x          <= '0;
      pen_y          <= '0;
      awaiting_first <= 1'b1;
      in_curve       <= 1'b0;
      s1_valid       <= 1'b0;
    end else begin
      if (point.ready) begin
        s1_valid <= point.valid;
      end
      if (in_fire) begin
        pen_x          <= pen_x_next;
        pen_y          <= pen_y_next;
        awaiting_first <= point.contour_end;
        in_curve       <= !aw_eff && !point.on_curve && !point.contour_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1.op     <= op_next;
      s1.cend   <= point.contour_end;
      s1.prev_x <= base_x;
      s1.prev_y <= base_y;
      s1.cur_x  <= pen_x_next;
      s1.cur_y  <= pen_y_next;
    end
  end

  // scale stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_take) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid) begin
      s2.op     <= s1.op;
      s2.cend   <= s1.cend;
      s2.prev_x <= scale_coord(s1.prev_x, scale);
      s2.prev_y <= scale_coord(s1.prev_y, scale);
      s2.cur_x  <= scale_coord(s1.cur_x, scale);
      s2.cur_y  <= scale_coord(s1.cur_y, scale);
    end
  end

  // segment build
  res_t   r0, r1;
  nres_t  nres;
  coord_t mid_x, mid_y;
  coord_t cs_x_next, cs_y_next, cc_x_next, cc_y_next;
  coord_t origin_x_next, origin_y_next;

  assign mid_x = midpoint(cc_x, s2.cur_x);
  assign mid_y = midpoint(cc_y, s2.cur_y);

  always_comb begin
    r0            = '0;
    r1            = '0;
    nres          = 2'd0;
    cs_x_next     = cs_x;
    cs_y_next     = cs_y;
    cc_x_next     = cc_x;
    cc_y_next     = cc_y;
    origin_x_next = origin_x;
    origin_y_next = origin_y;
    unique case (s2.op)
      OP_MARK: begin
        r0.kind       = KIND_MARK;
        nres          = 2'd1;
        origin_x_next = s2.cur_x;
        origin_y_next = s2.cur_y;
      end
      OP_LINE, OP_QUAD_ON: begin
        if (s2.op == OP_QUAD_ON) begin
          r0 = '{KIND_QUAD, cs_x, cs_y, cc_x, cc_y, s2.cur_x, s2.cur_y, 1'b0};
        end else begin
          r0 = '{KIND_LINE, s2.prev_x, s2.prev_y, '0, '0, s2.cur_x, s2.cur_y, 1'b0};
        end
        r1   = '{KIND_LINE, s2.cur_x, s2.cur_y, '0, '0, origin_x, origin_y, 1'b1};
        nres = s2.cend ? 2'd2 : 2'd1;
      end
      OP_OFF_FIRST: begin
        cs_x_next = s2.prev_x;
        cs_y_next = s2.prev_y;
        cc_x_next = s2.cur_x;
        cc_y_next = s2.cur_y;
        r0   = '{KIND_QUAD, s2.prev_x, s2.prev_y, s2.cur_x, s2.cur_y,
                 origin_x, origin_y, 1'b1};
        nres = s2.cend ? 2'd1 : 2'd0;
      end
      OP_OFF_MID: begin
        cs_x_next = mid_x;
        cs_y_next = mid_y;
        cc_x_next = s2.cur_x;
        cc_y_next = s2.cur_y;
        r0   = '{KIND_QUAD, cs_x, cs_y, cc_x, cc_y, mid_x, mid_y, 1'b0};
        r1   = '{KIND_QUAD, mid_x, mid_y, s2.cur_x, s2.cur_y, origin_x, origin_y, 1'b1};
        nres = s2.cend ? 2'd2 : 2'd1;
      end
      default: begin
        nres = 2'd0;
      end
    endcase
    r0.last = (nres == 2'd1) ? 1'b1 : r0.last;
  end

  assign s2_load = s2_valid && (buf_free || nres == 2'd0);
  assign s2_take = !s2_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      cs_x     <= '0;
      cs_y     <= '0;
      cc_x     <= '0;
      cc_y     <= '0;
    end else if (s2_load) begin
      origin_x <= origin_x_next;
      origin_y <= origin_y_next;
      cs_x     <= cs_x_next;
      cs_y     <= cs_y_next;
      cc_x     <= cc_x_next;
      cc_y     <= cc_y_next;
    end
  end

  gos_seg_buf u_buf (
    .clk  (clk),
    .rst  (rst),
    .load (s2_load),
    .nres (nres),
    .r0   (r0),
    .r1   (r1),
    .free (buf_free),
    .seg  (seg)
  );

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> point.ready)
    else $error("input not ready with empty accept stage");

  a_load_shows_word: assert property (@(posedge clk) disable iff (rst)
    s2_load && nres != 2'd0 |=> seg.valid)
    else $error("loaded result not presented");

  a_stage2_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_load |=> s2_valid)
    else $error("stalled scale stage lost its point");

  a_marker_single: assert property (@(posedge clk) disable iff (rst)
    s2_load && s2.op == OP_MARK |=> seg.valid && seg.last)
    else $error("contour marker not a single word");
`endif

endmodule
`default_nettype wire
